/* hdl/xtea_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_pkg
// Shared types, constants and the XTEA mixing function.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_KEYS   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CYCLES_DEF = 32;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3
  } cfg_reg_t;

  // Operation codes
  typedef enum logic {
    FUNC_ENCRYPT = 1'b0,
    FUNC_DECRYPT = 1'b1
  } func_t;

  typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

  // One block traveling down the round pipeline
  typedef struct packed {
    func_t             func;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } beat_t;

  function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] v);
    mix_word = ((v << 4) ^ (v >> 5)) + v;
  endfunction

endpackage
`default_nettype wire

/* hdl/xtea_block_cipher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_block_cipher
// Fully unrolled XTEA encrypt/decrypt pipeline, one 64-bit block per clock.
// ----------------------------------------------------------------------------
// Usage: a block is taken at every rising edge where start is high; busy is
// always low, so a new beat may be offered in every cycle. Each block flows
// through 2*CYCLES registered half-round stages (64 for the default CYCLES
// of 32); its result leaves the last stage register, marked by a
// one-cycle out_valid strobe. The receiver cannot stall the pipeline:
// capture the result in the strobe cycle or lose it. Sustained throughput
// is one block per clock.
// Blocks are big-endian: in_block_high holds bytes 0..3. in_func selects
// encrypt (0) or decrypt (1) per block. The 128-bit key lives in four
// 32-bit registers written through cfg_we/cfg_index/cfg_wdata; write them
// only while no block is in flight. Writes to indexes above three drop.
// ----------------------------------------------------------------------------
module xtea_block_cipher #(
  parameter int unsigned CYCLES = xtea_pkg::CYCLES_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  // block input
  input  wire                               start,
  output logic                              busy,
  input  wire                               in_func,
  input  wire  [xtea_pkg::WORD_W-1:0]       in_block_high,
  input  wire  [xtea_pkg::WORD_W-1:0]       in_block_low,
  // result output
  output logic                              out_valid,
  output logic [xtea_pkg::WORD_W-1:0]       out_result_high,
  output logic [xtea_pkg::WORD_W-1:0]       out_result_low,
  // key registers
  input  wire                               cfg_we,
  input  wire  [xtea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [xtea_pkg::WORD_W-1:0]       cfg_wdata
);

  localparam int unsigned STAGES = 2 * CYCLES;

  xtea_pkg::key_t  key_r, key_nxt;
  logic            valid_chain [STAGES+1];
  xtea_pkg::beat_t beat_chain  [STAGES+1];

  // Never back-pressure: the pipeline advances every clock.
  assign busy = 1'b0;

  // Key register writes; unknown indexes drop the write.
  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      unique case (cfg_index)
        xtea_pkg::REG_KEY_WORD_0: key_nxt[0] = cfg_wdata;
        xtea_pkg::REG_KEY_WORD_1: key_nxt[1] = cfg_wdata;
        xtea_pkg::REG_KEY_WORD_2: key_nxt[2] = cfg_wdata;
        xtea_pkg::REG_KEY_WORD_3: key_nxt[3] = cfg_wdata;
        default:                  key_nxt    = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  // Stage zero input: the accepted beat, packed as func, high word, low word.
  assign valid_chain[0] = start & ~busy;
  assign beat_chain[0]  = xtea_pkg::beat_t'({in_func, in_block_high, in_block_low});

  // One registered half-round per stage; the valid bit travels with the data.
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    xtea_stage #(
      .CYCLES (CYCLES),
      .STAGE  (g)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (valid_chain[g]),
      .beat_in   (beat_chain[g]),
      .key       (key_r),
      .valid_out (valid_chain[g+1]),
      .beat_out  (beat_chain[g+1])
    );
  end

  // Present the last stage directly: it is already a register.
  assign out_valid       = valid_chain[STAGES];
  assign out_result_high = beat_chain[STAGES].hi;
  assign out_result_low  = beat_chain[STAGES].lo;

endmodule
`default_nettype wire

/* hdl/xtea_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// xtea_stage
// One registered Feistel half-round. The running sum and key select are
// fixed per stage, so only the key word mux, two adds and one add/sub remain.
// ----------------------------------------------------------------------------
module xtea_stage #(
  parameter int unsigned CYCLES = xtea_pkg::CYCLES_DEF,
  parameter int unsigned STAGE  = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   valid_in,
  input  xtea_pkg::beat_t       beat_in,
  input  xtea_pkg::key_t        key,
  output logic                  valid_out,
  output xtea_pkg::beat_t       beat_out
);

  localparam int unsigned RND = STAGE / 2;
  localparam int unsigned ODD = STAGE % 2;

  // Encrypt: even stage updates hi with sum RND*delta, odd updates lo with (RND+1)*delta.
  // Decrypt: even stage updates lo with (CYCLES-RND)*delta, odd updates hi with one less.
  localparam logic [63:0] ENC_MUL = 64'(RND + ODD);
  localparam logic [63:0] DEC_MUL = 64'(CYCLES - RND - ODD);
  localparam logic [63:0] ENC_P   = ENC_MUL * {32'd0, xtea_pkg::DELTA};
  localparam logic [63:0] DEC_P   = DEC_MUL * {32'd0, xtea_pkg::DELTA};
  localparam logic [xtea_pkg::WORD_W-1:0] ENC_SUM = ENC_P[31:0];
  localparam logic [xtea_pkg::WORD_W-1:0] DEC_SUM = DEC_P[31:0];
  localparam logic [1:0] ENC_KIDX = (ODD == 0) ? ENC_SUM[1:0] : ENC_SUM[12:11];
  localparam logic [1:0] DEC_KIDX = (ODD == 0) ? DEC_SUM[12:11] : DEC_SUM[1:0];

  logic                          dec;
  logic                          upd_hi;
  logic [xtea_pkg::WORD_W-1:0]   src;
  logic [xtea_pkg::WORD_W-1:0]   dst;
  logic [xtea_pkg::WORD_W-1:0]   sum;
  logic [1:0]                    kidx;
  logic [xtea_pkg::WORD_W-1:0]   tweak;
  logic [xtea_pkg::WORD_W-1:0]   upd;
  logic                          valid_r, valid_nxt;
  xtea_pkg::beat_t               beat_r, beat_nxt;

  always_comb begin
    dec    = (beat_in.func == xtea_pkg::FUNC_DECRYPT);
    upd_hi = dec ? (ODD != 0) : (ODD == 0);
    src    = upd_hi ? beat_in.lo : beat_in.hi;
    dst    = upd_hi ? beat_in.hi : beat_in.lo;
    sum    = dec ? DEC_SUM : ENC_SUM;
    kidx   = dec ? DEC_KIDX : ENC_KIDX;
    tweak  = xtea_pkg::mix_word(src) ^ (sum + key[kidx]);
    upd    = dec ? (dst - tweak) : (dst + tweak);

    beat_nxt = beat_in;
    if (upd_hi) begin
      beat_nxt.hi = upd;
    end else begin
      beat_nxt.lo = upd;
    end
    valid_nxt = valid_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign valid_out = valid_r;
  assign beat_out  = beat_r;

endmodule
`default_nettype wire
